// ===== design/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the region sector allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int MAX_SECTORS   = 4096;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int SECT_AW       = $clog2(MAX_SECTORS);
  localparam int SCAN_W        = SECT_AW + 1;        // holds MAX_SECTORS itself
  localparam int WIDE_W        = 25;                 // 24-bit offset plus count
  localparam int NEED_W        = 13;
  localparam int CLR_N         = (MAX_SECTORS > TABLE_ENTRIES) ? MAX_SECTORS
                                                               : TABLE_ENTRIES;
  localparam int CLR_AW        = $clog2(CLR_N);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_PLACE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_NO_SPACE  = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    SEC_UNKNOWN = 2'd0,
    SEC_FREE    = 2'd1,
    SEC_USED    = 2'd2
  } sec_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_FREE,
    S_MARK
  } state_t;

  // sector map port controls
  typedef struct packed {
    logic               we;
    logic [SECT_AW-1:0] waddr;
    sec_t               wdata;
    logic [SECT_AW-1:0] raddr;
  } smap_req_t;

endpackage

`default_nettype wire

// ===== design/rsa_sector_map.sv =====
// ----------------------------------------------------------------------------
// rsa_sector_map
// Sector status memory with registered read, plus the scan view that treats
// the old range as free and anything past the end as unknown.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_sector_map (
  input  wire                               clk,
  input  rsa_pkg::smap_req_t                req,
  input  wire  [rsa_pkg::SCAN_W-1:0]        scan_addr,  // address of rdata
  input  wire  [23:0]                       old_first,
  input  wire  [rsa_pkg::WIDE_W-1:0]        old_end,
  output rsa_pkg::sec_t                     view
);
  import rsa_pkg::*;

  sec_t mem [MAX_SECTORS];
  sec_t rdata;

  logic [WIDE_W-1:0] s_wide;
  logic              in_old;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

  assign s_wide = WIDE_W'(scan_addr);
  assign in_old = (s_wide >= WIDE_W'(old_first)) && (s_wide < old_end);

  always_comb begin
    if (s_wide >= WIDE_W'(MAX_SECTORS)) begin
      view = SEC_UNKNOWN;
    end else if (in_old) begin
      view = SEC_FREE;
    end else begin
      view = rdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/region_sector_allocator_core.sv =====
// ----------------------------------------------------------------------------
// region_sector_allocator_core
// First-fit contiguous sector allocator for one region of 4096-byte sectors.
// ----------------------------------------------------------------------------
// Usage:
//   Command in: drive operation, chunk_x/z, entry_word, byte_length and pulse
//   start; the transfer happens on a clock edge with start high and busy low.
//   Result out: done is high for exactly one cycle with status, offset,
//   count, append_sectors, in_place and region_x/z. Every command gives one
//   result. The receiver cannot stall; results are simply presented.
// Steps (accept to done):
//   lookup, too-large, in-place, load of a zero word: no sector map walk.
//   load: table write, range mark walk.
//   place: scan only when out of space; otherwise scan, free walk of the old
//   range and mark walk of the new range. The scan and both range walks step
//   through the sector map one entry per cycle.
//   clear: one clearing sweep over both memories.
// One command is in flight at a time; busy stays high until its result.
// Reset: a clearing pass over MAX_SECTORS (4096) entries writes the table to
// zero and the sector map to sector 0 used, rest unknown; busy is high and
// no result is produced for it.
// ----------------------------------------------------------------------------
`default_nettype none

module region_sector_allocator_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire         [1:0]  operation,
  input  wire  signed [31:0] chunk_x,
  input  wire  signed [31:0] chunk_z,
  input  wire         [31:0] entry_word,
  input  wire         [23:0] byte_length,
  output logic               done,
  output logic        [1:0]  status,
  output logic        [11:0] sector_offset,
  output logic        [7:0]  sector_count,
  output logic        [7:0]  append_sectors,
  output logic               in_place,
  output logic signed [26:0] region_x,
  output logic signed [26:0] region_z
);
  import rsa_pkg::*;

  state_t state, state_next;

  // command registers
  op_t                 op;
  logic [TABLE_AW-1:0] idx;
  logic [31:0]         word;
  logic [NEED_W-1:0]   need;
  logic                clr_op;       // clear pass was requested by a command

  // location table: 1024 x 32, one write and one registered read port
  logic [31:0]         table_mem [TABLE_ENTRIES];
  logic [31:0]         table_rd;
  logic                tbl_we;
  logic [TABLE_AW-1:0] tbl_waddr;
  logic [31:0]         tbl_wdata;
  logic [TABLE_AW-1:0] in_idx;

  // old entry of the chunk being placed
  logic [23:0]         old_first;
  logic [7:0]          old_count;
  logic [WIDE_W-1:0]   old_end;

  // scan and walk state
  logic [SCAN_W-1:0]   scan_addr;
  logic [SCAN_W-1:0]   scan_next;
  logic [SCAN_W-1:0]   run_start;
  logic [7:0]          run;
  logic [23:0]         mark_first;
  logic [7:0]          mark_count;
  logic [7:0]          walk_i;
  logic [CLR_AW-1:0]   clr_cnt;

  smap_req_t           smap_req;
  sec_t                view;

  // decode helpers
  logic [24:0]         len_p4;
  logic                accept;
  logic                too_large;
  logic                reuse;
  logic [8:0]          run_inc;
  logic                found;
  logic                no_space;
  logic                clr_last;
  logic [WIDE_W-1:0]   walk_addr;
  logic                walk_end;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign in_idx    = {chunk_z[4:0], chunk_x[4:0]};
  assign len_p4    = {1'b0, byte_length} + 25'd4;

  // decisions made in FETCH on the table word just read
  assign too_large = (need > NEED_W'(255));
  assign reuse     = (table_rd[31:8] != 24'd0) && ({5'd0, table_rd[7:0]} == need);

  // scan step on the status of scan_addr
  assign scan_next = scan_addr + SCAN_W'(1);
  assign run_inc   = {1'b0, run} + 9'd1;
  assign found     = (view == SEC_FREE) && (NEED_W'(run_inc) >= need);
  assign no_space  = (WIDE_W'(run_start) + WIDE_W'(need)) > WIDE_W'(MAX_SECTORS);

  assign clr_last  = (clr_cnt == CLR_AW'(CLR_N - 1));

  // range walk: old range in FREE, new range in MARK
  always_comb begin
    if (state == S_FREE) begin
      walk_addr = WIDE_W'(old_first) + WIDE_W'(walk_i);
      walk_end  = (walk_i == old_count);
    end else begin
      walk_addr = WIDE_W'(mark_first) + WIDE_W'(walk_i);
      walk_end  = (walk_i == mark_count);
    end
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (op_t'(operation) == OP_CLEAR) ? S_CLEAR : S_FETCH;
        end
      end
      S_FETCH: begin
        case (op)
          OP_LOAD:   state_next = (word != 32'd0) ? S_MARK : S_IDLE;
          OP_PLACE:  state_next = (too_large || reuse) ? S_IDLE : S_SCAN;
          default:   state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (view == SEC_UNKNOWN) begin
          state_next = no_space ? S_IDLE : S_FREE;
        end else if (found) begin
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        if (walk_end) state_next = S_MARK;
      end
      S_MARK: begin
        if (walk_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    smap_req.we    = 1'b0;
    smap_req.waddr = walk_addr[SECT_AW-1:0];
    smap_req.wdata = SEC_USED;
    smap_req.raddr = (state == S_SCAN) ? scan_next[SECT_AW-1:0] : '0;
    tbl_we         = 1'b0;
    tbl_waddr      = idx;
    tbl_wdata      = word;
    case (state)
      S_CLEAR: begin
        smap_req.we    = (CLR_AW'(clr_cnt) < CLR_AW'(MAX_SECTORS - 1)) ||
                         (clr_cnt == CLR_AW'(MAX_SECTORS - 1));
        smap_req.waddr = clr_cnt[SECT_AW-1:0];
        smap_req.wdata = (clr_cnt == '0) ? SEC_USED : SEC_UNKNOWN;
        tbl_we         = (clr_cnt < CLR_AW'(TABLE_ENTRIES - 1)) ||
                         (clr_cnt == CLR_AW'(TABLE_ENTRIES - 1));
        tbl_waddr      = clr_cnt[TABLE_AW-1:0];
        tbl_wdata      = 32'd0;
      end
      S_FETCH: begin
        tbl_we = (op == OP_LOAD);
      end
      S_SCAN: begin
        // commit the new entry once the placement is known to succeed
        tbl_we    = found || ((view == SEC_UNKNOWN) && !no_space);
        tbl_wdata = {24'(run_start), need[7:0]};
      end
      S_FREE: begin
        smap_req.we    = !walk_end && (walk_addr < WIDE_W'(MAX_SECTORS));
        smap_req.wdata = SEC_FREE;
      end
      S_MARK: begin
        smap_req.we    = !walk_end && (walk_addr < WIDE_W'(MAX_SECTORS));
        smap_req.wdata = SEC_USED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[tbl_waddr] <= tbl_wdata;
    end
    table_rd <= table_mem[in_idx];
  end

  rsa_sector_map u_smap (
    .clk       (clk),
    .req       (smap_req),
    .scan_addr (scan_addr),
    .old_first (old_first),
    .old_end   (old_end),
    .view      (view)
  );

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      clr_op  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_AW'(1);
          done    <= clr_last && clr_op;
          if (clr_last) begin
            clr_op <= 1'b0;
          end
        end
        S_IDLE: begin
          clr_cnt <= '0;
          clr_op  <= accept && (op_t'(operation) == OP_CLEAR);
          done    <= 1'b0;
        end
        default: begin
          done <= (state_next == S_IDLE);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op             <= op_t'(operation);
          idx            <= in_idx;
          word           <= entry_word;
          need           <= len_p4[24:12] + NEED_W'(1);
          region_x       <= chunk_x[31:5];
          region_z       <= chunk_z[31:5];
          status         <= STAT_OK;
          sector_offset  <= 12'd0;
          sector_count   <= 8'd0;
          append_sectors <= 8'd0;
          in_place       <= 1'b0;
        end
      end
      S_FETCH: begin
        old_first <= table_rd[31:8];
        old_count <= table_rd[7:0];
        old_end   <= WIDE_W'(table_rd[31:8]) + WIDE_W'(table_rd[7:0]);
        scan_addr <= '0;
        run_start <= '0;
        run       <= 8'd0;
        walk_i    <= 8'd0;
        case (op)
          OP_LOAD: begin
            mark_first    <= word[31:8];
            mark_count    <= word[7:0];
            sector_offset <= word[19:8];
            sector_count  <= word[7:0];
          end
          OP_LOOKUP: begin
            status        <= (table_rd == 32'd0) ? STAT_EMPTY : STAT_OK;
            sector_offset <= table_rd[19:8];
            sector_count  <= table_rd[7:0];
          end
          OP_PLACE: begin
            if (too_large) begin
              status <= STAT_TOO_LARGE;
            end else if (reuse) begin
              sector_offset <= table_rd[19:8];
              sector_count  <= need[7:0];
              in_place      <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        scan_addr <= scan_next;
        if (view == SEC_UNKNOWN) begin
          // hit the end of the known file: the rest of the run is appended
          sector_count <= need[7:0];
          if (no_space) begin
            status <= STAT_NO_SPACE;
          end else begin
            sector_offset  <= 12'(WIDE_W'(run_start));
            append_sectors <= need[7:0] - run;
            mark_first     <= 24'(run_start);
            mark_count     <= need[7:0];
          end
        end else if (view == SEC_FREE) begin
          run <= run_inc[7:0];
          if (found) begin
            sector_offset <= 12'(WIDE_W'(run_start));
            sector_count  <= need[7:0];
            mark_first    <= 24'(run_start);
            mark_count    <= need[7:0];
          end
        end else begin
          run_start <= scan_next;
          run       <= 8'd0;
        end
      end
      S_FREE: begin
        walk_i <= walk_end ? 8'd0 : walk_i + 8'd1;
      end
      S_MARK: begin
        walk_i <= walk_i + 8'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
